/* rtl/obsi_pkg.sv */
// Package: shared types, constants and codes for the order book sweep impact block.
package obsi_pkg;

    localparam int BookLevelsDefault = 64;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_ASK     = 2'd1,
        OP_BID     = 2'd2,
        OP_QUERY   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // queue entry from front to back
    typedef struct packed {
        opcode_t     op;
        logic [23:0] price;
        logic [23:0] quantity;
        logic        is_buy;
    } cmd_t;

endpackage

/* rtl/obsi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module obsi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/obsi_front.sv */
// Front part: accept input words and place them in a two-entry queue.
module obsi_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  obsi_pkg::cmd_t  in_cmd,
    output logic            q_valid,
    input  logic            q_take,
    output obsi_pkg::cmd_t  q_cmd
);

    obsi_pkg::cmd_t slot_reg [2];
    logic [1:0]     cnt_reg;
    logic           rd_reg;
    logic           wr_reg;
    logic           push;
    logic           pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_cmd    = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* rtl/obsi_back.sv */
// Back part: book storage, sweep sequencer, impact divider and output register.
module obsi_back #(
    parameter int BOOK_LEVELS = obsi_pkg::BookLevelsDefault
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_take,
    input  obsi_pkg::cmd_t  q_cmd,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      status,
    output logic [23:0]     filled_quantity,
    output logic [31:0]     impact_ratio
);

    localparam int AW = (BOOK_LEVELS > 1) ? $clog2(BOOK_LEVELS) : 1;
    localparam int CW = $clog2(BOOK_LEVELS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_BEST, S_SWEEP, S_MUL, S_PREP, S_DIV, S_DONE
    } state_t;

    state_t      state_reg;
    logic [CW-1:0] ask_cnt_reg, bid_cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [AW-1:0] rd_addr;
    logic [23:0] ap_rd, aq_rd, bp_rd, bq_rd;
    logic [23:0] ask_best_reg, bid_best_reg;
    logic        buy_reg;
    logic [23:0] rem_reg, filled_reg;
    logic [57:0] w_reg;
    logic [24:0] mid2_reg;
    logic [57:0] num_reg, den_reg;
    logic [58:0] rem_div_reg;
    logic [31:0] quo_reg;
    logic [6:0]  step_reg;
    logic [5:0]  bit_sel;
    logic        lvl_valid_reg;
    logic [23:0] take;
    logic [23:0] lvl_p, lvl_q;
    logic [47:0] prod;
    logic [1:0]  st_reg;
    logic [58:0] trial;
    logic [57:0] a2;
    logic [48:0] b_raw;
    logic [57:0] b_prod;

    logic wr_ask, wr_bid;
    assign wr_ask = (state_reg == S_IDLE) && q_valid && !out_valid
                    && q_cmd.op == obsi_pkg::OP_ASK && ask_cnt_reg < CW'(BOOK_LEVELS);
    assign wr_bid = (state_reg == S_IDLE) && q_valid && !out_valid
                    && q_cmd.op == obsi_pkg::OP_BID && bid_cnt_reg < CW'(BOOK_LEVELS);

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = idx_reg[AW-1:0];
        end
    end

    obsi_ram #(.WIDTH(24), .DEPTH(BOOK_LEVELS)) u_ap (.clk(clk), .wr_en(wr_ask),
        .wr_addr(ask_cnt_reg[AW-1:0]), .wr_data(q_cmd.price), .rd_addr(rd_addr),
        .rd_data(ap_rd));
    obsi_ram #(.WIDTH(24), .DEPTH(BOOK_LEVELS)) u_aq (.clk(clk), .wr_en(wr_ask),
        .wr_addr(ask_cnt_reg[AW-1:0]), .wr_data(q_cmd.quantity), .rd_addr(rd_addr),
        .rd_data(aq_rd));
    obsi_ram #(.WIDTH(24), .DEPTH(BOOK_LEVELS)) u_bp (.clk(clk), .wr_en(wr_bid),
        .wr_addr(bid_cnt_reg[AW-1:0]), .wr_data(q_cmd.price), .rd_addr(rd_addr),
        .rd_data(bp_rd));
    obsi_ram #(.WIDTH(24), .DEPTH(BOOK_LEVELS)) u_bq (.clk(clk), .wr_en(wr_bid),
        .wr_addr(bid_cnt_reg[AW-1:0]), .wr_data(q_cmd.quantity), .rd_addr(rd_addr),
        .rd_data(bq_rd));

    assign q_take  = (state_reg == S_IDLE) && !out_valid;
    assign lvl_p   = buy_reg ? ap_rd : bp_rd;
    assign lvl_q   = buy_reg ? aq_rd : bq_rd;
    assign take    = (lvl_q < rem_reg) ? lvl_q : rem_reg;
    assign prod    = lvl_p * take;
    assign a2      = {w_reg[56:0], 1'b0};
    assign b_raw   = mid2_reg * filled_reg;
    assign b_prod  = {9'd0, b_raw};
    assign trial   = {rem_div_reg[57:0], 1'b0};
    assign bit_sel = 6'd57 - step_reg[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ask_cnt_reg   <= '0;
            bid_cnt_reg   <= '0;
            out_valid     <= 1'b0;
            idx_reg       <= '0;
            lvl_valid_reg <= 1'b0;
            step_reg      <= '0;
            st_reg        <= 2'd0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && !out_valid)
                    begin
                        status          <= obsi_pkg::ST_OK;
                        filled_quantity <= '0;
                        impact_ratio    <= '0;
                        case (q_cmd.op)
                            obsi_pkg::OP_CLEAR:
                            begin
                                ask_cnt_reg <= '0;
                                bid_cnt_reg <= '0;
                                out_valid   <= 1'b1;
                            end
                            obsi_pkg::OP_ASK:
                            begin
                                if (wr_ask)
                                    ask_cnt_reg <= ask_cnt_reg + 1'b1;
                                else
                                    status <= obsi_pkg::ST_FULL;
                                out_valid <= 1'b1;
                            end
                            obsi_pkg::OP_BID:
                            begin
                                if (wr_bid)
                                    bid_cnt_reg <= bid_cnt_reg + 1'b1;
                                else
                                    status <= obsi_pkg::ST_FULL;
                                out_valid <= 1'b1;
                            end
                            default:
                            begin
                                buy_reg <= q_cmd.is_buy;
                                rem_reg <= q_cmd.quantity;
                                if ((q_cmd.is_buy ? ask_cnt_reg : bid_cnt_reg) == '0)
                                begin
                                    status    <= obsi_pkg::ST_EMPTY;
                                    out_valid <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_BEST;
                                end
                            end
                        endcase
                    end
                end
                S_BEST:
                begin
                    // best levels read at address zero; start the sweep
                    ask_best_reg  <= ap_rd;
                    bid_best_reg  <= bp_rd;
                    w_reg         <= '0;
                    filled_reg    <= '0;
                    idx_reg       <= CW'(1);
                    lvl_valid_reg <= 1'b1;
                    state_reg     <= S_SWEEP;
                end
                S_SWEEP:
                begin
                    // one level a cycle; read of the next address already issued
                    if (lvl_valid_reg && rem_reg != '0)
                    begin
                        w_reg      <= w_reg + 58'(prod);
                        filled_reg <= filled_reg + take;
                        rem_reg    <= rem_reg - take;
                        lvl_valid_reg <= (idx_reg < (buy_reg ? ask_cnt_reg : bid_cnt_reg));
                        idx_reg    <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        if (ask_cnt_reg != '0 && bid_cnt_reg != '0)
                            mid2_reg <= {1'b0, ask_best_reg} + {1'b0, bid_best_reg};
                        else
                            mid2_reg <= buy_reg ? {ask_best_reg, 1'b0} : {bid_best_reg, 1'b0};
                        idx_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    st_reg  <= (rem_reg != '0) ? obsi_pkg::ST_SHORT : obsi_pkg::ST_OK;
                    den_reg <= b_prod;
                    num_reg <= (a2 >= b_prod) ? a2 - b_prod : b_prod - a2;
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    rem_div_reg <= '0;
                    quo_reg     <= '0;
                    step_reg    <= '0;
                    if (filled_reg == '0)
                    begin
                        impact_ratio <= '0;
                        state_reg    <= S_DONE;
                    end
                    else if (den_reg == '0)
                    begin
                        impact_ratio <= (num_reg != '0) ? 32'hFFFF_FFFF : 32'd0;
                        state_reg    <= S_DONE;
                    end
                    else if ({8'd0, num_reg} >= {den_reg, 8'd0})
                    begin
                        impact_ratio <= 32'hFFFF_FFFF;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // restoring division of num * 2^24 by den, one bit a cycle
                    if (step_reg < 7'd58)
                    begin
                        if ((trial | 59'(num_reg[bit_sel])) >= {1'b0, den_reg})
                        begin
                            rem_div_reg <= (trial | 59'(num_reg[bit_sel]))
                                           - {1'b0, den_reg};
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_div_reg <= trial | 59'(num_reg[bit_sel]);
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                        step_reg <= step_reg + 1'b1;
                    end
                    else if (step_reg < 7'd82)
                    begin
                        if (trial >= {1'b0, den_reg})
                        begin
                            rem_div_reg <= trial - {1'b0, den_reg};
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_div_reg <= trial;
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                        step_reg <= step_reg + 1'b1;
                    end
                    else
                    begin
                        impact_ratio <= quo_reg;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    status          <= st_reg;
                    filled_quantity <= filled_reg;
                    out_valid       <= 1'b1;
                    state_reg       <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/order_book_sweep_impact_core.sv */
// Top level: order book sweep and market impact block.
// A clear or append word is offered as a result in the cycle after the sequencer
// takes it, and so is a query on an empty side. Any other query is handed over and
// the best levels fetched; then the sweep walks the book memories one level a
// cycle over L levels, L being the number of levels swept (at most BOOK_LEVELS);
// the ratio operands are formed; the restoring divider resolves one bit of the
// Q8.24 impact a cycle; and the output register is loaded. Saturating and
// degenerate cases skip the divider. The sequencer takes the next word only once
// the result has been taken, so a stalled output holds everything behind it. A
// two-word queue sits between the input port and the sequencer, and the result
// is held in an output register until taken. Memory contents need no clearing
// pass: level counts bound every read.
module order_book_sweep_impact_core #(
    parameter int BOOK_LEVELS = obsi_pkg::BookLevelsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [23:0] price,
    input  logic [23:0] quantity,
    input  logic        is_buy,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [23:0] filled_quantity,
    output logic [31:0] impact_ratio
);

    obsi_pkg::cmd_t in_cmd;
    obsi_pkg::cmd_t q_cmd;
    logic           q_valid;
    logic           q_take;

    // pack the input word
    assign in_cmd.op       = obsi_pkg::opcode_t'(opcode);
    assign in_cmd.price    = price;
    assign in_cmd.quantity = quantity;
    assign in_cmd.is_buy   = is_buy;

    obsi_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
    );

    obsi_back #(.BOOK_LEVELS(BOOK_LEVELS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .filled_quantity(filled_quantity), .impact_ratio(impact_ratio)
    );

endmodule

/* verif/order_book_sweep_impact_core_test.sv */
// Testbench for the order book sweep impact core: predicted sweeps checked word by word.
module order_book_sweep_impact_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Levels = obsi_pkg::BookLevelsDefault;
    localparam longint CycleLimit = 3000000;

    // One expected result word.
    typedef struct {
        obsi_pkg::status_t status;
        logic [23:0]       filled;
        logic [31:0]       impact;
    } sweep_result_t;

    // Holds its own copy of the book and the queue of predicted results.
    class impact_scoreboard;
        logic [23:0] ask_px[Levels];
        logic [23:0] ask_qty[Levels];
        logic [23:0] bid_px[Levels];
        logic [23:0] bid_qty[Levels];
        int ask_depth;
        int bid_depth;
        sweep_result_t pending[$];
        int errors;

        function new();
            ask_depth = 0;
            bid_depth = 0;
            errors = 0;
        endfunction

        // floor(num * 2^24 / den), saturated to 32 bits
        function logic [31:0] q824(logic [63:0] num, logic [63:0] den);
            logic [63:0] whole;
            logic [63:0] rem;
            logic [23:0] frac;
            frac = '0;
            if (num >= (den << 8))
                return 32'hFFFF_FFFF;
            whole = num / den;
            rem = num % den;
            for (int i = 0; i < 24; i++)
            begin
                rem = rem << 1;
                frac = frac << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    frac[0] = 1'b1;
                end
            end
            return {whole[7:0], frac};
        endfunction

        function void note_word(obsi_pkg::opcode_t op, logic [23:0] px, logic [23:0] qty,
                                logic buy);
            sweep_result_t r;
            int depth;
            logic [23:0] remaining;
            logic [23:0] take;
            logic [63:0] weighted;
            logic [63:0] mid2;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] num;
            r.status = obsi_pkg::ST_OK;
            r.filled = '0;
            r.impact = '0;
            case (op)
                obsi_pkg::OP_CLEAR:
                begin
                    ask_depth = 0;
                    bid_depth = 0;
                end
                obsi_pkg::OP_ASK:
                    if (ask_depth >= Levels)
                        r.status = obsi_pkg::ST_FULL;
                    else
                    begin
                        ask_px[ask_depth] = px;
                        ask_qty[ask_depth] = qty;
                        ask_depth++;
                    end
                obsi_pkg::OP_BID:
                    if (bid_depth >= Levels)
                        r.status = obsi_pkg::ST_FULL;
                    else
                    begin
                        bid_px[bid_depth] = px;
                        bid_qty[bid_depth] = qty;
                        bid_depth++;
                    end
                default:
                begin
                    depth = buy ? ask_depth : bid_depth;
                    if (depth == 0)
                        r.status = obsi_pkg::ST_EMPTY;
                    else
                    begin
                        remaining = qty;
                        weighted = '0;
                        for (int i = 0; i < depth && remaining != 0; i++)
                        begin
                            take = buy ? ask_qty[i] : bid_qty[i];
                            if (take > remaining)
                                take = remaining;
                            weighted += 64'(buy ? ask_px[i] : bid_px[i]) * 64'(take);
                            r.filled += take;
                            remaining -= take;
                        end
                        r.status = remaining != 0 ? obsi_pkg::ST_SHORT : obsi_pkg::ST_OK;
                        if (ask_depth > 0 && bid_depth > 0)
                            mid2 = 64'(ask_px[0]) + 64'(bid_px[0]);
                        else
                            mid2 = 64'(buy ? ask_px[0] : bid_px[0]) * 2;
                        if (r.filled != 0)
                        begin
                            a = weighted * 2;
                            b = mid2 * 64'(r.filled);
                            num = a >= b ? a - b : b - a;
                            if (b == 0)
                                r.impact = num != 0 ? 32'hFFFF_FFFF : 32'd0;
                            else
                                r.impact = q824(num, b);
                        end
                    end
                end
            endcase
            pending.insert(pending.size(), r);
        endfunction

        function void check_word(logic [1:0] st, logic [23:0] fq, logic [31:0] ir);
            sweep_result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word status %0d filled %0d impact %h",
                         $time, st, fq, ir);
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (st !== e.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            end
            if (fq !== e.filled)
            begin
                errors++;
                $display("%0t: filled_quantity expected %0d actual %0d", $time, e.filled, fq);
            end
            if (ir !== e.impact)
            begin
                errors++;
                $display("%0t: impact_ratio expected %h actual %h", $time, e.impact, ir);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [23:0] price = '0;
    logic [23:0] quantity = '0;
    logic        is_buy = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [23:0] filled_quantity;
    logic [31:0] impact_ratio;

    impact_scoreboard board;
    longint cycle_count = 0;
    bit     quiet_phase = 1'b0;  // no idling on either side
    bit     hold_receiver = 1'b0;

    order_book_sweep_impact_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .price(price), .quantity(quantity), .is_buy(is_buy),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .filled_quantity(filled_quantity), .impact_ratio(impact_ratio)
    );

    always #6 clk = ~clk;

    // Score both ports at the edge, from values settled before it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_word(obsi_pkg::opcode_t'(opcode), price, quantity, is_buy);
            if (out_valid && !out_stall)
                board.check_word(status, filled_quantity, impact_ratio);
        end
    end

    // Watchdog: give up after a generous cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("order_book_sweep_impact_core_test failed");
            $finish;
        end
    end

    // Receiver: stall in random bursts, or hold off for a long stretch on request.
    initial
    begin
        int burst;
        @(posedge rst_n);
        forever
        begin
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                hold_receiver = 1'b0;
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
                @(posedge clk);
        end
    end

    // Offer one word and hold it until taken; a random gap may follow.
    task automatic send_word(obsi_pkg::opcode_t op, logic [23:0] px, logic [23:0] qty,
                             logic buy);
        int gap;
        opcode <= op;
        price <= px;
        quantity <= qty;
        is_buy <= buy;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted word has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [23:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return 24'($urandom_range(1, 16));
            3: return 24'($urandom_range(1000, 1100));
            default: return 24'($urandom);
        endcase
    endfunction

    // Build a book with prices near a common level, then fire a few queries.
    task automatic build_and_query(int asks, int bids, int queries);
        logic [23:0] base;
        logic [23:0] step;
        base = $urandom_range(0, 3) == 0 ? pick_value() : 24'($urandom_range(100, 100000));
        step = 24'($urandom_range(0, 50));
        send_word(obsi_pkg::OP_CLEAR, pick_value(), pick_value(), 1'($urandom));
        for (int i = 0; i < asks; i++)
            send_word(obsi_pkg::OP_ASK,
                      $urandom_range(0, 4) == 0 ? pick_value() : 24'(base + step * i),
                      $urandom_range(0, 3) == 0 ? pick_value() : 24'($urandom_range(1, 500)),
                      1'($urandom));
        for (int i = 0; i < bids; i++)
            send_word(obsi_pkg::OP_BID, $urandom_range(0, 4) == 0 ? pick_value() :
                      24'(base > step * (i + 1) ? base - step * (i + 1) : 24'd0),
                      $urandom_range(0, 3) == 0 ? pick_value() : 24'($urandom_range(1, 500)),
                      1'($urandom));
        for (int i = 0; i < queries; i++)
            send_word(obsi_pkg::OP_QUERY, pick_value(),
                      $urandom_range(0, 3) == 0 ? pick_value() : 24'($urandom_range(0, 3000)),
                      1'($urandom));
    endtask

    initial
    begin
        int sent;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty sides, zero sizes, zero mid, saturation.
        send_word(obsi_pkg::OP_QUERY, 24'd0, 24'd5, 1'b1);
        send_word(obsi_pkg::OP_QUERY, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0);
        send_word(obsi_pkg::OP_ASK, 24'd0, 24'd10, 1'b0);
        send_word(obsi_pkg::OP_QUERY, 24'd0, 24'd4, 1'b1);
        send_word(obsi_pkg::OP_ASK, 24'd5, 24'd10, 1'b1);
        send_word(obsi_pkg::OP_QUERY, 24'd0, 24'd15, 1'b1);
        send_word(obsi_pkg::OP_QUERY, 24'd0, 24'd0, 1'b1);
        send_word(obsi_pkg::OP_CLEAR, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
        send_word(obsi_pkg::OP_ASK, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
        send_word(obsi_pkg::OP_ASK, 24'h00_0001, 24'h00_0001, 1'b0);
        send_word(obsi_pkg::OP_BID, 24'd1, 24'hFF_FFFF, 1'b0);
        send_word(obsi_pkg::OP_QUERY, 24'd0, 24'hFF_FFFF, 1'b1);
        send_word(obsi_pkg::OP_QUERY, 24'd0, 24'hFF_FFFF, 1'b0);
        send_word(obsi_pkg::OP_BID, 24'd0, 24'd0, 1'b1);
        send_word(obsi_pkg::OP_QUERY, 24'd0, 24'hFF_FFFF, 1'b0);
        send_word(obsi_pkg::OP_QUERY, 24'hAA_AAAA, 24'h55_5555, 1'b1);
        drain_results();

        // Fill both sides past capacity, sweep the full depth.
        build_and_query(Levels + 2, Levels + 2, 4);
        send_word(obsi_pkg::OP_QUERY, 24'd0, 24'hFF_FFFF, 1'b1);
        send_word(obsi_pkg::OP_QUERY, 24'd0, 24'hFF_FFFF, 1'b0);

        // Receiver holds off while words keep coming, so the input backs up.
        hold_receiver = 1'b1;
        build_and_query(3, 3, 6);
        while (hold_receiver)
            @(posedge clk);
        drain_results();

        // Random books: mostly well-formed, some noise.
        sent = 0;
        while (sent < 1600)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(obsi_pkg::opcode_t'($urandom_range(0, 3)), 24'($urandom),
                          24'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                int na;
                int nb;
                int nq;
                na = $urandom_range(0, 20) == 0 ? $urandom_range(0, Levels + 1) :
                     $urandom_range(0, 6);
                nb = $urandom_range(0, 20) == 0 ? $urandom_range(0, Levels + 1) :
                     $urandom_range(0, 6);
                nq = $urandom_range(1, 5);
                build_and_query(na, nb, nq);
                sent += 1 + na + nb + nq;
            end
        end

        // Final stretch with no idling on either side.
        quiet_phase = 1'b1;
        for (int i = 0; i < 15; i++)
            build_and_query($urandom_range(1, 5), $urandom_range(1, 5), 3);
        drain_results();
        repeat (200) @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("order_book_sweep_impact_core_test passed");
        else
            $display("order_book_sweep_impact_core_test failed");
        $finish;
    end
endmodule

/* order_book_sweep_impact_core.f */
rtl/obsi_pkg.sv
rtl/obsi_ram.sv
rtl/obsi_front.sv
rtl/obsi_back.sv
rtl/order_book_sweep_impact_core.sv
verif/order_book_sweep_impact_core_test.sv
